// ===== hdl/iccapp2_pkg.sv =====
// shared types and constants for the icc profile app2 segmenter
// no dependencies; compiled first

package iccapp2_pkg;

    localparam int unsigned MAX_SEGMENT_DATA = 65519;
    localparam int unsigned SEG_HDR_EXTRA    = 16;

    localparam logic [15:0] SEG_DATA_MAX = 16'(MAX_SEGMENT_DATA);
    localparam logic [15:0] SEG_LEN_ADD  = 16'(SEG_HDR_EXTRA);

    // beat positions within one item's run
    localparam logic [4:0] BEAT_MARK_FF  = 5'd0;
    localparam logic [4:0] BEAT_MARK_E2  = 5'd1;
    localparam logic [4:0] BEAT_LEN_HI   = 5'd2;
    localparam logic [4:0] BEAT_LEN_LO   = 5'd3;
    localparam logic [4:0] BEAT_ID_FIRST = 5'd4;
    localparam logic [4:0] BEAT_ID_LAST  = 5'd15;
    localparam logic [4:0] BEAT_SEG_NUM  = 5'd16;
    localparam logic [4:0] BEAT_SEG_TOT  = 5'd17;
    localparam logic [4:0] BEAT_DATA     = 5'd18;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] MARKER_APP2   = 8'hE2;

    typedef struct packed {
        logic [7:0]  data;
        logic        ovr;
        logic        hdr;
        logic        seg_end;
        logic [15:0] mlen;
        logic [7:0]  seg_num;
        logic [7:0]  seg_total;
    } item_desc_t;

    // segment identifier text and its zero terminator
    function automatic logic [7:0] id_text_byte(input logic [3:0] pos);
        logic [7:0] b;
        case (pos)
            4'd0:    b = 8'h49;
            4'd1:    b = 8'h43;
            4'd2:    b = 8'h43;
            4'd3:    b = 8'h5F;
            4'd4:    b = 8'h50;
            4'd5:    b = 8'h52;
            4'd6:    b = 8'h4F;
            4'd7:    b = 8'h46;
            4'd8:    b = 8'h49;
            4'd9:    b = 8'h4C;
            4'd10:   b = 8'h45;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/iccapp2_if.sv =====
// channel interfaces: profile byte input, framed stream output, length config
// depends on nothing beyond the language

interface iccapp2_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
    modport mon    (input valid, input data_byte, input ready);
endinterface

interface iccapp2_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       segment_end;
    logic       overrun;

    modport source (output valid, output out_byte, output last_of_run,
                    output segment_end, output overrun, input ready);
    modport sink   (input valid, input out_byte, input last_of_run,
                    input segment_end, input overrun, output ready);
    modport mon    (input valid, input out_byte, input last_of_run,
                    input segment_end, input overrun, input ready);
endinterface

interface iccapp2_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] profile_length;

    modport source (output valid, output profile_length, input ready);
    modport sink   (input valid, input profile_length, output ready);
    modport mon    (input valid, input profile_length, input ready);
endinterface

// ===== hdl/iccapp2_tracker.sv =====
// framing state: bytes left, segment position, segment number and count
// depends on iccapp2_pkg

module iccapp2_tracker
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr,
    input  logic [23:0]              cfg_len,
    input  logic                     take,
    input  logic [7:0]               data_byte,
    output iccapp2_pkg::item_desc_t  desc
);
    import iccapp2_pkg::*;

    logic [23:0] remain_reg,  remain_next;
    logic [15:0] left_reg,    left_next;
    logic [7:0]  num_reg,     num_next;
    logic [7:0]  total_reg,   total_next;

    logic        at_end;
    logic        need_hdr;
    logic [15:0] seglen;
    logic [15:0] left_cur;
    logic [7:0]  num_inc;

    // ceil(len / 65519): estimate by >>16, remainder check corrects once
    function automatic logic [7:0] seg_count(input logic [23:0] len);
        logic [24:0] y;
        logic [8:0]  q;
        logic [12:0] q17;
        logic [16:0] r;
        logic [8:0]  qc;
        y   = {1'b0, len} + 25'(MAX_SEGMENT_DATA - 1);
        q   = y[24:16];
        q17 = {q, 4'b0000} + {4'b0000, q};
        r   = {1'b0, y[15:0]} + {4'b0000, q17};
        qc  = (r >= 17'(MAX_SEGMENT_DATA)) ? q + 9'd1 : q;
        return qc[7:0];
    endfunction

    assign at_end   = (remain_reg == 24'd0);
    assign need_hdr = (left_reg == 16'd0);
    assign seglen   = (remain_reg > {8'd0, SEG_DATA_MAX}) ? SEG_DATA_MAX : remain_reg[15:0];
    assign num_inc  = num_reg + 8'd1;
    assign left_cur = (need_hdr ? seglen : left_reg) - 16'd1;

    always_comb
    begin
        desc.data      = data_byte;
        desc.ovr       = at_end;
        desc.hdr       = need_hdr && !at_end;
        desc.seg_end   = (left_cur == 16'd0);
        desc.mlen      = seglen + SEG_LEN_ADD;
        desc.seg_num   = num_inc;
        desc.seg_total = total_reg;
    end

    always_comb
    begin
        remain_next = remain_reg;
        left_next   = left_reg;
        num_next    = num_reg;
        total_next  = total_reg;
        if (cfg_wr)
        begin
            remain_next = cfg_len;
            left_next   = 16'd0;
            num_next    = 8'd0;
            total_next  = seg_count(cfg_len);
        end
        else if (take && !at_end)
        begin
            remain_next = remain_reg - 24'd1;
            left_next   = left_cur;
            if (need_hdr)
            begin
                num_next = num_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 24'd0;
            left_reg   <= 16'd0;
            num_reg    <= 8'd0;
            total_reg  <= 8'd0;
        end
        else
        begin
            remain_reg <= remain_next;
            left_reg   <= left_next;
            num_reg    <= num_next;
            total_reg  <= total_next;
        end
    end

endmodule

// ===== hdl/icc_profile_app2_segmenter_top.sv =====
// icc profile to jpeg app2 segment framer, top level
// depends on iccapp2_pkg, iccapp2_if and iccapp2_tracker
//
// profile: one profile byte per beat, taken when valid and ready are high
// stream:  framed marker stream, one byte per beat; last_of_run marks the
//          final beat caused by an input byte, segment_end the closing byte
//          of a segment, overrun a byte that came after the profile's end
// cfg:     profile_length write, always ready; restarts framing
// an input byte that opens a segment gives 19 beats (18 header bytes, then
// the data byte), any other byte gives one beat
// an input byte is registered in the item register, then each of its beats in
// the output register
// throughput: one byte per cycle inside a segment while stream.ready is high,
// less for the byte that opens a segment, set by the single output byte lane
// the next input byte is taken in the cycle the current run's last beat
// moves into the output register, so the output register parts both sides
// a stalled receiver holds the output beat and, once the item register is
// full, drops profile.ready
// reset: profile_length 0, so every input reports overrun until written

module icc_profile_app2_segmenter_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    iccapp2_in_if.sink           profile,
    iccapp2_out_if.source        stream,
    iccapp2_cfg_if.sink          cfg
);
    import iccapp2_pkg::*;

    item_desc_t  desc;
    item_desc_t  item_reg;
    logic        item_v_reg,  item_v_next;
    logic [4:0]  beat_reg,    beat_next;
    logic        out_v_reg,   out_v_next;
    logic [7:0]  obyte_reg;
    logic        olast_reg;
    logic        oend_reg;
    logic        oovr_reg;

    logic        take;
    logic        out_load;
    logic        item_done;
    logic [7:0]  beat_byte;
    logic [4:0]  id_pos;

    assign cfg.ready     = 1'b1;
    assign out_load      = item_v_reg && (!out_v_reg || stream.ready);
    assign item_done     = (beat_reg == BEAT_DATA);
    assign profile.ready = !item_v_reg || (item_done && out_load);
    assign take          = profile.valid && profile.ready;

    iccapp2_tracker u_tracker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg.valid),
        .cfg_len   (cfg.profile_length),
        .take      (take),
        .data_byte (profile.data_byte),
        .desc      (desc)
    );

    assign id_pos = beat_reg - BEAT_ID_FIRST;

    always_comb
    begin
        case (beat_reg)
            BEAT_MARK_FF: beat_byte = MARKER_PREFIX;
            BEAT_MARK_E2: beat_byte = MARKER_APP2;
            BEAT_LEN_HI:  beat_byte = item_reg.mlen[15:8];
            BEAT_LEN_LO:  beat_byte = item_reg.mlen[7:0];
            BEAT_SEG_NUM: beat_byte = item_reg.seg_num;
            BEAT_SEG_TOT: beat_byte = item_reg.seg_total;
            BEAT_DATA:    beat_byte = item_reg.ovr ? 8'h00 : item_reg.data;
            default:
            begin
                if (beat_reg >= BEAT_ID_FIRST && beat_reg <= BEAT_ID_LAST)
                    beat_byte = id_text_byte(id_pos[3:0]);
                else
                    beat_byte = 8'h00;
            end
        endcase
    end

    always_comb
    begin
        item_v_next = item_v_reg;
        beat_next   = beat_reg;
        if (take)
        begin
            item_v_next = 1'b1;
            beat_next   = desc.hdr ? BEAT_MARK_FF : BEAT_DATA;
        end
        else if (out_load)
        begin
            if (item_done)
                item_v_next = 1'b0;
            else
                beat_next = beat_reg + 5'd1;
        end
        out_v_next = out_load || (out_v_reg && !stream.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            beat_reg   <= BEAT_DATA;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            item_v_reg <= item_v_next;
            beat_reg   <= beat_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= desc;
        end
        if (out_load)
        begin
            obyte_reg <= beat_byte;
            olast_reg <= item_done;
            oend_reg  <= item_done && !item_reg.ovr && item_reg.seg_end;
            oovr_reg  <= item_done && item_reg.ovr;
        end
    end

    assign stream.valid       = out_v_reg;
    assign stream.out_byte    = obyte_reg;
    assign stream.last_of_run = olast_reg;
    assign stream.segment_end = oend_reg;
    assign stream.overrun     = oovr_reg;

endmodule

// ===== hdl/iccapp2_checker.sv =====
// port-level checks on the segmenter's output stream, bound to the top level
// depends on icc_profile_app2_segmenter_top

module iccapp2_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       valid,
    input logic       ready,
    input logic [7:0] out_byte,
    input logic       last_of_run,
    input logic       segment_end,
    input logic       overrun
);

    // held beat while stalled
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("stream beat dropped while stalled");

    a_hold_byte: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> $stable(out_byte))
        else $error("stream byte changed while stalled");

    // overrun is a lone zero byte that closes its run
    a_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        valid && overrun |->
            last_of_run && !segment_end && out_byte == 8'h00)
        else $error("malformed overrun beat");

    // a segment only closes on a data byte
    a_seg_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid && segment_end |-> last_of_run)
        else $error("segment end outside a data byte");

endmodule

bind icc_profile_app2_segmenter_top iccapp2_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .valid       (stream.valid),
    .ready       (stream.ready),
    .out_byte    (stream.out_byte),
    .last_of_run (stream.last_of_run),
    .segment_end (stream.segment_end),
    .overrun     (stream.overrun)
);

// ===== verif/icc_profile_app2_segmenter_top_tb.sv =====
// testbench for icc_profile_app2_segmenter_top: feeds profile bytes, predicts the
// framed app2 marker stream and checks it beat by beat, with random idling both sides
// depends on iccapp2_pkg, iccapp2_if and the segmenter rtl
`timescale 1ns / 100ps

module icc_profile_app2_segmenter_top_tb;

    import iccapp2_pkg::*;

    localparam int unsigned QUIET_LIMIT   = 1000;
    localparam int unsigned RANDOM_BYTES  = 460;
    localparam int unsigned CALM_FROM     = 380;
    localparam int unsigned REPORT_LINES  = 40;
    localparam logic [23:0] LEN_MAX_FULL  = 24'd16707345;
    localparam logic [23:0] LEN_ALL_ONES  = 24'hFFFFFF;

    localparam logic [7:0] ICC_TAG [12] = '{
        8'h49, 8'h43, 8'h43, 8'h5F, 8'h50, 8'h52,
        8'h4F, 8'h46, 8'h49, 8'h4C, 8'h45, 8'h00
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       segment_end;
        logic       overrun;
    } stream_beat_t;

    logic clk;
    logic rst_n;

    iccapp2_in_if  profile_bus ();
    iccapp2_out_if stream_bus ();
    iccapp2_cfg_if cfg_bus ();

    icc_profile_app2_segmenter_top u_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .profile (profile_bus),
        .stream  (stream_bus),
        .cfg     (cfg_bus)
    );

    logic [7:0]   profile_bytes_q [$];
    stream_beat_t framed_beats_q [$];

    // framing state as the block should hold it
    logic [23:0] bytes_left;
    logic [15:0] seg_left;
    logic [7:0]  seg_num;
    logic [7:0]  seg_total;

    int unsigned feed_gap_odds;
    int unsigned sink_stall_odds;
    int unsigned feed_gap;
    int unsigned sink_stall;
    int unsigned quiet_cycles;
    int unsigned mismatch_count;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_framing(input logic [23:0] len);
        logic [31:0] segs;
        bytes_left = len;
        seg_left   = '0;
        seg_num    = '0;
        segs       = (32'(len) + MAX_SEGMENT_DATA - 1) / MAX_SEGMENT_DATA;
        seg_total  = segs[7:0];
    endfunction

    function automatic void push_header_byte(input logic [7:0] b);
        framed_beats_q.push_back(stream_beat_t'{out_byte: b, last_of_run: 1'b0,
                                                segment_end: 1'b0, overrun: 1'b0});
    endfunction

    function automatic void frame_profile_byte(input logic [7:0] b);
        logic [15:0] seg_len;
        logic [15:0] mlen;
        if (bytes_left == '0)
        begin
            framed_beats_q.push_back(stream_beat_t'{out_byte: 8'h00, last_of_run: 1'b1,
                                                    segment_end: 1'b0, overrun: 1'b1});
            return;
        end
        if (seg_left == '0)
        begin
            seg_len = (bytes_left > MAX_SEGMENT_DATA) ? SEG_DATA_MAX : bytes_left[15:0];
            mlen    = seg_len + SEG_LEN_ADD;
            seg_num = seg_num + 8'd1;
            push_header_byte(MARKER_PREFIX);
            push_header_byte(MARKER_APP2);
            push_header_byte(mlen[15:8]);
            push_header_byte(mlen[7:0]);
            foreach (ICC_TAG[i])
                push_header_byte(ICC_TAG[i]);
            push_header_byte(seg_num);
            push_header_byte(seg_total);
            seg_left = seg_len;
        end
        seg_left   = seg_left - 16'd1;
        bytes_left = bytes_left - 24'd1;
        framed_beats_q.push_back(stream_beat_t'{out_byte: b, last_of_run: 1'b1,
                                                segment_end: (seg_left == '0),
                                                overrun: 1'b0});
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < REPORT_LINES)
            $display("%0t ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_stream_beat();
        stream_beat_t want;
        if (framed_beats_q.size() == 0)
        begin
            report_mismatch($sformatf("beat with nothing pending, out_byte %02h",
                                      stream_bus.out_byte));
        end
        else
        begin
            want = framed_beats_q.pop_front();
            if (stream_bus.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte got %02h want %02h",
                                          stream_bus.out_byte, want.out_byte));
            if (stream_bus.last_of_run !== want.last_of_run)
                report_mismatch($sformatf("last_of_run got %b want %b",
                                          stream_bus.last_of_run, want.last_of_run));
            if (stream_bus.segment_end !== want.segment_end)
                report_mismatch($sformatf("segment_end got %b want %b",
                                          stream_bus.segment_end, want.segment_end));
            if (stream_bus.overrun !== want.overrun)
                report_mismatch($sformatf("overrun got %b want %b",
                                          stream_bus.overrun, want.overrun));
        end
    endtask

    // profile byte driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            profile_bus.valid     <= 1'b0;
            profile_bus.data_byte <= '0;
            feed_gap              <= 0;
        end
        else if (!profile_bus.valid || profile_bus.ready)
        begin
            if (feed_gap != 0)
            begin
                feed_gap          <= feed_gap - 1;
                profile_bus.valid <= 1'b0;
            end
            else if (profile_bytes_q.size() == 0)
            begin
                profile_bus.valid <= 1'b0;
            end
            else if (feed_gap_odds != 0 && $urandom_range(1, feed_gap_odds) == 1)
            begin
                feed_gap          <= $urandom_range(0, 17);
                profile_bus.valid <= 1'b0;
            end
            else
            begin
                profile_bus.valid     <= 1'b1;
                profile_bus.data_byte <= profile_bytes_q.pop_front();
            end
        end
    end

    // stream receiver with stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bus.ready <= 1'b0;
            sink_stall       <= 0;
        end
        else if (sink_stall != 0)
        begin
            sink_stall       <= sink_stall - 1;
            stream_bus.ready <= 1'b0;
        end
        else if (sink_stall_odds != 0 && $urandom_range(1, sink_stall_odds) == 1)
        begin
            sink_stall       <= $urandom_range(0, 17);
            stream_bus.ready <= 1'b0;
        end
        else
        begin
            stream_bus.ready <= 1'b1;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (stream_bus.valid && stream_bus.ready)
                check_stream_beat();
            if (profile_bus.valid && profile_bus.ready)
                frame_profile_byte(profile_bus.data_byte);
            if (cfg_bus.valid && cfg_bus.ready)
                restart_framing(cfg_bus.profile_length);
        end
    end

    // watchdog on cycles with no beat anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (profile_bus.valid && profile_bus.ready)
            || (stream_bus.valid && stream_bus.ready)
            || (cfg_bus.valid && cfg_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("icc_profile_app2_segmenter_top verification failed");
            $finish;
        end
    end

    task automatic write_profile_length(input logic [23:0] len);
        @(posedge clk);
        cfg_bus.valid          <= 1'b1;
        cfg_bus.profile_length <= len;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        while (profile_bytes_q.size() != 0 || profile_bus.valid || framed_beats_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic push_random_bytes(input int unsigned n);
        repeat (n)
            profile_bytes_q.push_back(8'($urandom()));
    endtask

    function automatic int unsigned pick_idle_odds();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 8;
        endcase
    endfunction

    initial
    begin
        logic [23:0]  len;
        int unsigned  n;
        int unsigned  random_bytes_sent;

        rst_n                 = 1'b0;
        cfg_bus.valid         = 1'b0;
        cfg_bus.profile_length = '0;
        feed_gap_odds         = 4;
        sink_stall_odds       = 4;
        mismatch_count        = 0;
        random_bytes_sent     = 0;
        restart_framing('0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // nothing configured after reset, so every byte overruns
        profile_bytes_q = '{8'h00, 8'hFF};
        wait_idle();

        write_profile_length(24'd1);
        profile_bytes_q = '{8'hFF, 8'h00};
        wait_idle();

        write_profile_length(24'd3);
        profile_bytes_q = '{8'h80, 8'h7F, 8'h01, 8'hFE};
        wait_idle();

        write_profile_length(24'd0);
        profile_bytes_q = '{8'h55};
        wait_idle();

        write_profile_length(LEN_MAX_FULL);
        profile_bytes_q = '{8'hAA, 8'h55, 8'hC3};
        wait_idle();

        // segment total wraps to the low 8 bits
        write_profile_length(LEN_ALL_ONES);
        profile_bytes_q = '{8'h3C, 8'h96};
        wait_idle();

        while (random_bytes_sent < RANDOM_BYTES)
        begin
            if (random_bytes_sent >= CALM_FROM)
            begin
                feed_gap_odds   = 0;
                sink_stall_odds = 0;
            end
            else
            begin
                feed_gap_odds   = pick_idle_odds();
                sink_stall_odds = pick_idle_odds();
            end
            case ($urandom_range(0, 9))
                6, 7:
                begin
                    len = 24'($urandom());
                    n   = $urandom_range(1, 24);
                end
                8:
                begin
                    len = 24'($urandom_range(MAX_SEGMENT_DATA - 3, MAX_SEGMENT_DATA + 3));
                    n   = $urandom_range(1, 6);
                end
                9:
                begin
                    len = 24'($urandom_range(0, 1));
                    n   = $urandom_range(1, 3);
                end
                default:
                begin
                    len = 24'($urandom_range(1, 40));
                    n   = 32'(len) + $urandom_range(0, 2);
                end
            endcase
            write_profile_length(len);
            push_random_bytes(n);
            wait_idle();
            random_bytes_sent += n;
        end

        repeat (20) @(negedge clk);
        if (framed_beats_q.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", framed_beats_q.size()));

        if (mismatch_count == 0)
            $display("icc_profile_app2_segmenter_top verification clean");
        else
            $display("icc_profile_app2_segmenter_top verification failed");
        $finish;
    end

endmodule
